@@ rtl/core/epfm_pkg.sv @@
`timescale 1ns / 1ps
// Package for the edge period frequency meter: widths, limits, register indexes.
// No dependencies; imported by edge_period_frequency_meter.
package epfm_pkg;

    // Timeout and fixed-point settings
    localparam int STAGE_TIMEOUT_US = 20000;
    localparam int FRAC_BITS        = 16;

    // Counter and delay widths
    localparam int CNT_W  = 27;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam int MS_W   = 16;
    localparam int TPU_W  = 10;
    localparam int TNS_W  = 10;
    localparam int DLY_W  = 36;
    localparam int US_PER_MS = 1000;

    // Shared multiplier operand and product widths
    localparam int MA_W   = 27;
    localparam int MB_W   = 17;
    localparam int PROD_W = MA_W + MB_W;
    localparam int MSP_W  = MS_W + TPU_W;
    localparam int LIM_W  = CNT_W + 3;

    // Period and reciprocal
    localparam int P_W    = CNT_W + TNS_W;
    localparam logic [P_W-1:0] PERIOD_LIMIT_NS = P_W'(40000000);
    localparam int DEN_W  = 26;
    localparam int NUM_W  = 47;
    localparam int DCNT_W = $clog2(NUM_W);
    localparam logic [NUM_W-1:0] NUM_BASE = NUM_W'(64'd1000000000 << FRAC_BITS);
    localparam int FREQ_W = 46;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int IDX_W  = ADDR_W - 2;
    localparam logic [IDX_W-1:0] REG_CTRL_EN    = 3'd0;
    localparam logic [IDX_W-1:0] REG_EN_LEVEL   = 3'd1;
    localparam logic [IDX_W-1:0] REG_SETTLE_ON  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SETTLE_OFF = 3'd3;
    localparam logic [IDX_W-1:0] REG_TPU        = 3'd4;
    localparam logic [IDX_W-1:0] REG_TICK_NS    = 3'd5;

    // Clamp a timeout sum to the elapsed counter range
    function automatic logic [CNT_W-1:0] sat_cnt(input logic [LIM_W-1:0] x);
        if (x > LIM_W'(CNT_MAX)) begin
            return CNT_MAX;
        end
        return x[CNT_W-1:0];
    endfunction

endpackage

@@ rtl/core/edge_period_frequency_meter.sv @@
`timescale 1ns / 1ps
// Edge period frequency meter: tick-driven edge search, period capture and
// reciprocal in Q30.16. Depends on epfm_pkg.
//
// Channel   Dir  Width  Fields (low bit up)
// s stream  in   8      start_req[0], probe_level[1], zero pad
// m stream  out  56     control_level[0], busy_res[1], done_res[2], read_ok[3],
//                       frequency[49:4], zero pad
// APB       cfg  32     six registers at byte addresses 0x00..0x14
//
// One input word is one reference tick and yields one output word. The tick that
// ends a measurement runs the shared multiplier for the period, then a restoring
// divider one quotient bit per cycle, or skips the divider for a read error. After
// reset and after any register write, a sequencer recomputes the timeout limits and
// settle delays with the same multiplier; s_tready stays low meanwhile. Reset is
// synchronous and active low. A waiting output word holds off the next input word.
module edge_period_frequency_meter
    import epfm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input stream
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [7:0]          i_s_tdata,   // start_req, probe_level
    // Output stream
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [55:0]         o_m_tdata,   // control_level, busy_res, done_res,
                                             // read_ok, frequency
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETTLE_ON,
        PH_SEEK_RISE1,
        PH_SEEK_FALL1,
        PH_SEEK_RISE2,
        PH_SEEK_FALL2,
        PH_SETTLE_OFF
    } t_phase;

    typedef enum logic [3:0] {
        SQ_CFG_BASE,
        SQ_CFG_LIM,
        SQ_CFG_ON,
        SQ_CFG_ONW,
        SQ_CFG_OFF,
        SQ_CFG_OFFW,
        SQ_RUN,
        SQ_MUL_P,
        SQ_CHECK,
        SQ_DIV
    } t_seq;

    // Configuration registers
    logic                r_ctrl_en;
    logic                r_en_level;
    logic [MS_W-1:0]     r_settle_on;
    logic [MS_W-1:0]     r_settle_off;
    logic [TPU_W-1:0]    r_tpu;
    logic [TNS_W-1:0]    r_tick_ns;

    // Derived timing values
    logic [CNT_W-1:0]    r_lim1, r_lim2, r_lim3, r_lim4;
    logic [DLY_W-1:0]    r_dly_on, r_dly_off;

    // Measurement state
    t_phase              r_phase;
    logic [CNT_W-1:0]    r_elapsed;
    logic [CNT_W-1:0]    r_period;
    logic [DLY_W-1:0]    r_delay;
    logic                r_en;
    logic [FREQ_W-1:0]   r_res_value;
    logic                r_res_valid;

    // Sequencer, shared multiplier, divider, output
    t_seq                r_seq;
    logic [PROD_W-1:0]   r_prod;
    logic [NUM_W-1:0]    r_num;
    logic [DEN_W-1:0]    r_rem;
    logic [DEN_W-1:0]    r_den;
    logic [DCNT_W-1:0]   r_cnt;
    logic                r_out_valid;
    logic                r_out_done;

    // Next values of one tick
    t_phase              n_phase;
    logic [CNT_W-1:0]    n_elapsed;
    logic [CNT_W-1:0]    n_period;
    logic [DLY_W-1:0]    n_delay;
    logic                n_en;
    logic                n_done;
    logic                n_need_div;

    logic                start_req;
    logic                probe_level;
    logic                s_accept;
    logic                cfg_wr;
    logic [IDX_W-1:0]    cfg_idx;

    logic [MA_W-1:0]     mul_a;
    logic [MB_W-1:0]     mul_b;
    logic [PROD_W-1:0]   mul_p;

    logic [LIM_W-1:0]    base_x;
    logic [LIM_W-1:0]    base_x3;
    logic [P_W-1:0]      per_ns;

    logic [DEN_W:0]      rem_sh;
    logic                q_bit;
    logic [DEN_W:0]      rem_sub;
    logic [NUM_W-1:0]    num_nx;

    assign start_req   = i_s_tdata[0];
    assign probe_level = i_s_tdata[1];
    assign o_s_tready  = (r_seq == SQ_RUN) && (!r_out_valid || i_m_tready);
    assign s_accept    = i_s_tvalid && o_s_tready;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_W-1:2];

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_res_value, r_res_valid, r_out_done,
                         (r_phase != PH_IDLE), r_en};

    // Register readback
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_CTRL_EN:    prdata = 32'(r_ctrl_en);
            REG_EN_LEVEL:   prdata = 32'(r_en_level);
            REG_SETTLE_ON:  prdata = 32'(r_settle_on);
            REG_SETTLE_OFF: prdata = 32'(r_settle_off);
            REG_TPU:        prdata = 32'(r_tpu);
            REG_TICK_NS:    prdata = 32'(r_tick_ns);
            default:        prdata = '0;
        endcase
    end

    // Shared multiplier: operands picked by the sequencer step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_seq)
            SQ_CFG_BASE: begin
                mul_a = MA_W'(r_tpu);
                mul_b = MB_W'(STAGE_TIMEOUT_US);
            end
            SQ_CFG_LIM: begin
                mul_a = MA_W'(r_settle_on);
                mul_b = MB_W'(r_tpu);
            end
            SQ_CFG_ON, SQ_CFG_OFF: begin
                mul_a = MA_W'(r_prod[MSP_W-1:0]);
                mul_b = MB_W'(US_PER_MS);
            end
            SQ_CFG_ONW: begin
                mul_a = MA_W'(r_settle_off);
                mul_b = MB_W'(r_tpu);
            end
            SQ_MUL_P: begin
                mul_a = MA_W'(r_period);
                mul_b = MB_W'(r_tick_ns);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Stage timeouts are 1x..4x the base; form them by shift and one add
    assign base_x  = LIM_W'(r_prod[CNT_W-1:0]);
    assign base_x3 = base_x + (base_x << 1);

    assign per_ns = r_prod[P_W-1:0];

    // Restoring divider step: one quotient bit a cycle
    assign rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign q_bit   = rem_sh >= {1'b0, r_den};
    assign rem_sub = q_bit ? (rem_sh - {1'b0, r_den}) : rem_sh;
    assign num_nx  = {r_num[NUM_W-2:0], q_bit};

    // One reference tick: delays, cascaded edge search, end of measurement
    always_comb begin
        n_phase    = r_phase;
        n_elapsed  = r_elapsed;
        n_period   = r_period;
        n_delay    = r_delay;
        n_en       = r_en;
        n_done     = 1'b0;
        n_need_div = 1'b0;

        // Advance the search counters, saturating
        if (r_phase == PH_SEEK_RISE1 || r_phase == PH_SEEK_FALL1 ||
            r_phase == PH_SEEK_RISE2 || r_phase == PH_SEEK_FALL2) begin
            if (r_elapsed < CNT_MAX) begin
                n_elapsed = r_elapsed + 1'b1;
            end
            if ((r_phase == PH_SEEK_RISE2 || r_phase == PH_SEEK_FALL2) &&
                r_period < CNT_MAX) begin
                n_period = r_period + 1'b1;
            end
        end

        case (r_phase)
            PH_IDLE: begin
                if (start_req) begin
                    if (r_ctrl_en) begin
                        n_en = r_en_level;
                    end
                    if (r_ctrl_en && r_dly_on != '0) begin
                        n_phase = PH_SETTLE_ON;
                        n_delay = r_dly_on;
                    end else begin
                        n_phase   = PH_SEEK_RISE1;
                        n_elapsed = '0;
                    end
                end
            end
            PH_SETTLE_ON: begin
                if (r_delay != '0) begin
                    n_delay = r_delay - 1'b1;
                end
                if (n_delay == '0) begin
                    n_phase   = PH_SEEK_RISE1;
                    n_elapsed = '0;
                end
            end
            PH_SETTLE_OFF: begin
                if (r_delay != '0) begin
                    n_delay = r_delay - 1'b1;
                end
                if (n_delay == '0) begin
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Several search stages may end on the same tick
        if (n_phase == PH_SEEK_RISE1) begin
            if (probe_level || n_elapsed >= r_lim1) begin
                n_phase = PH_SEEK_FALL1;
            end
        end
        if (n_phase == PH_SEEK_FALL1) begin
            if (!probe_level || n_elapsed >= r_lim2) begin
                n_phase  = PH_SEEK_RISE2;
                n_period = '0;
            end
        end
        if (n_phase == PH_SEEK_RISE2) begin
            if (probe_level || n_elapsed >= r_lim3) begin
                n_phase = PH_SEEK_FALL2;
            end
        end
        if (n_phase == PH_SEEK_FALL2) begin
            if (!probe_level || n_elapsed >= r_lim4) begin
                n_need_div = 1'b1;
                if (r_ctrl_en) begin
                    n_en = ~r_en_level;
                end
                if (r_ctrl_en && r_dly_off != '0) begin
                    n_phase = PH_SETTLE_OFF;
                    n_delay = r_dly_off;
                end else begin
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
            end
        end
    end

    // Sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (!i_rst_n) begin
            r_ctrl_en    <= 1'b0;
            r_en_level   <= 1'b1;
            r_settle_on  <= '0;
            r_settle_off <= '0;
            r_tpu        <= TPU_W'(240);
            r_tick_ns    <= TNS_W'(4);
            r_phase      <= PH_IDLE;
            r_elapsed    <= '0;
            r_period     <= '0;
            r_delay      <= '0;
            r_en         <= 1'b0;
            r_res_value  <= '0;
            r_res_valid  <= 1'b0;
            r_seq        <= SQ_CFG_BASE;
            r_out_valid  <= 1'b0;
            r_out_done   <= 1'b0;
        end else begin
            // Drop the output word once taken
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_seq)
                SQ_CFG_BASE: r_seq <= SQ_CFG_LIM;
                SQ_CFG_LIM: begin
                    r_lim1 <= sat_cnt(base_x);
                    r_lim2 <= sat_cnt(base_x << 1);
                    r_lim3 <= sat_cnt(base_x3);
                    r_lim4 <= sat_cnt(base_x << 2);
                    r_seq  <= SQ_CFG_ON;
                end
                SQ_CFG_ON: r_seq <= SQ_CFG_ONW;
                SQ_CFG_ONW: begin
                    r_dly_on <= r_prod[DLY_W-1:0];
                    r_seq    <= SQ_CFG_OFF;
                end
                SQ_CFG_OFF: r_seq <= SQ_CFG_OFFW;
                SQ_CFG_OFFW: begin
                    r_dly_off <= r_prod[DLY_W-1:0];
                    r_seq     <= SQ_RUN;
                end
                SQ_RUN: begin
                    if (s_accept) begin
                        r_phase    <= n_phase;
                        r_elapsed  <= n_elapsed;
                        r_period   <= n_period;
                        r_delay    <= n_delay;
                        r_en       <= n_en;
                        r_out_done <= n_done;
                        if (n_need_div) begin
                            r_seq <= SQ_MUL_P;
                        end else begin
                            r_out_valid <= 1'b1;
                        end
                    end
                end
                SQ_MUL_P: r_seq <= SQ_CHECK;
                SQ_CHECK: begin
                    if (per_ns == '0 || per_ns >= PERIOD_LIMIT_NS) begin
                        r_res_value <= '0;
                        r_res_valid <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_seq       <= SQ_RUN;
                    end else begin
                        // Round to nearest: add half the divisor
                        r_num <= NUM_BASE + NUM_W'(per_ns[P_W-1:1]);
                        r_den <= per_ns[DEN_W-1:0];
                        r_rem <= '0;
                        r_cnt <= DCNT_W'(NUM_W - 1);
                        r_seq <= SQ_DIV;
                    end
                end
                SQ_DIV: begin
                    r_num <= num_nx;
                    r_rem <= rem_sub[DEN_W-1:0];
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_res_value <= num_nx[FREQ_W-1:0];
                        r_res_valid <= 1'b1;
                        r_out_valid <= 1'b1;
                        r_seq       <= SQ_RUN;
                    end
                end
                default: r_seq <= SQ_CFG_BASE;
            endcase

            // Register write: store and recompute the derived timing
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_CTRL_EN:    r_ctrl_en    <= pwdata[0];
                    REG_EN_LEVEL:   r_en_level   <= pwdata[0];
                    REG_SETTLE_ON:  r_settle_on  <= pwdata[MS_W-1:0];
                    REG_SETTLE_OFF: r_settle_off <= pwdata[MS_W-1:0];
                    REG_TPU:        r_tpu        <= pwdata[TPU_W-1:0];
                    REG_TICK_NS:    r_tick_ns    <= pwdata[TNS_W-1:0];
                    default: begin
                    end
                endcase
                r_seq <= SQ_CFG_BASE;
            end
        end
    end

endmodule
